// ===== rtl/vrp_pkg.sv =====
`default_nettype none
package vrp_pkg;

	localparam int unsigned NumDivCells = 24;

	typedef enum logic [2:0] {
		REG_COS_PITCH  = 3'd0,
		REG_SIN_PITCH  = 3'd1,
		REG_COS_YAW    = 3'd2,
		REG_SIN_YAW    = 3'd3,
		REG_CAMERA     = 3'd4,
		REG_GAIN_X     = 3'd5,
		REG_GAIN_Y     = 3'd6,
		REG_NONE       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [7:0] model_x;
		logic signed [7:0] model_y;
		logic signed [7:0] model_z;
		logic              end_of_object;
	} vertex_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic signed [15:0] rotated_depth;
		logic               depth_zero;
		logic               last_vertex;
	} result_t;

	typedef struct packed {
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic signed [15:0] cos_yaw;
		logic signed [15:0] sin_yaw;
		logic signed [15:0] camera_distance;
		logic signed [15:0] gain_x;
		logic signed [15:0] gain_y;
	} cfg_t;

	// numerator shifts out at the top while quotient bits shift in below
	typedef struct packed {
		logic [23:0] nq;
		logic [9:0]  rem;
		logic        neg;
	} div_lane_t;

	typedef struct packed {
		logic [10:0]        dmag;
		logic signed [15:0] depth;
		logic               zero;
		logic               last;
	} div_side_t;

endpackage
`default_nettype wire

// ===== rtl/vertex_rotate_project_unit.sv =====
`default_nettype none
// Pipeline from vertex accept to result valid: 6 rotate/setup stages,
// 24 divider cells, one gain multiply stage, one output register.
// Throughput: one vertex per cycle unless the output stalls; each divider cell resolves one quotient bit.
// The whole pipeline holds while a result waits on result_ready.
// Reset: arst_n clears all valid bits and loads the register reset values.
module vertex_rotate_project_unit #(
	parameter int CENTER_X = 32,
	parameter int CENTER_Y = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vertex_valid,
	output logic                  vertex_ready,
	input  wire vrp_pkg::vertex_t vertex,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output vrp_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [4:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import vrp_pkg::*;

	cfg_t cfg;
	logic adv;

	vrp_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	logic     result_valid_q;
	result_t  result_q;

	assign adv          = !result_valid_q || result_ready;
	assign vertex_ready = adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [7:0]  x_s1, y_s1, z_s1;
	logic               last_s1;
	logic signed [15:0] xcp_s2, zsp_s2, zcp_s2, xsp_s2, ycy_s2, ysy_s2;
	logic               last_s2;
	logic signed [15:0] x_s3, z_s3, ycy_s3, ysy_s3;
	logic               last_s3;
	logic signed [15:0] x_s4, ycy_s4, ysy_s4, zsy_s4, zcy_s4;
	logic               last_s4;
	logic signed [15:0] x_s5, y_s5, z_s5;
	logic               last_s5;

	logic signed [23:0] m_xcp, m_zsp, m_zcp, m_xsp, m_ycy, m_ysy;
	logic signed [31:0] m_zsy, m_zcy;

	always_comb begin
		m_xcp = x_s1 * cfg.cos_pitch;
		m_zsp = z_s1 * cfg.sin_pitch;
		m_zcp = z_s1 * cfg.cos_pitch;
		m_xsp = x_s1 * cfg.sin_pitch;
		m_ycy = y_s1 * cfg.cos_yaw;
		m_ysy = y_s1 * cfg.sin_yaw;
		m_zsy = z_s3 * cfg.sin_yaw;
		m_zcy = z_s3 * cfg.cos_yaw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vertex_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= vertex.model_x; y_s1 <= vertex.model_y; z_s1 <= vertex.model_z;
			last_s1 <= vertex.end_of_object;
			// x*256 >> 8 is exact, so the pitch terms need only the low 16 bits
			xcp_s2 <= m_xcp[15:0]; zsp_s2 <= m_zsp[15:0];
			zcp_s2 <= m_zcp[15:0]; xsp_s2 <= m_xsp[15:0];
			ycy_s2 <= m_ycy[15:0]; ysy_s2 <= m_ysy[15:0];
			last_s2 <= last_s1;
			x_s3 <= xcp_s2 + zsp_s2;
			z_s3 <= zcp_s2 - xsp_s2;
			ycy_s3 <= ycy_s2; ysy_s3 <= ysy_s2; last_s3 <= last_s2;
			x_s4 <= x_s3; ycy_s4 <= ycy_s3; ysy_s4 <= ysy_s3;
			zsy_s4 <= m_zsy[23:8]; zcy_s4 <= m_zcy[23:8];
			last_s4 <= last_s3;
			x_s5 <= x_s4;
			y_s5 <= ycy_s4 + zsy_s4;
			z_s5 <= zcy_s4 - ysy_s4;
			last_s5 <= last_s4;
		end
	end

	// divider setup
	logic signed [15:0] dsum;
	logic signed [10:0] dv;
	logic [15:0]        ax, ay;
	div_side_t          side_d;
	div_lane_t [1:0]    lane_d;

	always_comb begin
		dsum = z_s5 + cfg.camera_distance;
		dv   = dsum[15:5];
		ax   = x_s5[15] ? 16'(-x_s5) : x_s5;
		ay   = y_s5[15] ? 16'(-y_s5) : y_s5;
		side_d.dmag  = dv[10] ? 11'(-dv) : dv;
		side_d.depth = z_s5;
		side_d.zero  = (dv == 11'sd0);
		side_d.last  = last_s5;
		lane_d[0].nq  = {ax, 8'd0};
		lane_d[0].rem = 10'd0;
		lane_d[0].neg = x_s5[15] ^ dv[10];
		lane_d[1].nq  = {ay, 8'd0};
		lane_d[1].rem = 10'd0;
		lane_d[1].neg = y_s5[15] ^ dv[10];
	end

	div_side_t       side_c  [NumDivCells+1];
	div_lane_t [1:0] lane_c  [NumDivCells+1];
	logic            valid_c [NumDivCells+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_c[0] <= side_d;
			lane_c[0] <= lane_d;
		end
	end

	assign valid_c[0] = v_s6;

	for (genvar g = 0; g < NumDivCells; g++) begin : g_cell
		vrp_div_cell u_cell (
			.clk, .arst_n, .en(adv),
			.valid_i(valid_c[g]), .side_i(side_c[g]), .lane_i(lane_c[g]),
			.valid_q(valid_c[g+1]), .side_q(side_c[g+1]), .lane_q(lane_c[g+1])
		);
	end

	// gain multiply
	div_side_t          side_f;
	div_lane_t [1:0]    lane_f;
	logic signed [15:0] qx, qy;
	logic signed [31:0] m_gx, m_gy;
	logic signed [15:0] gx_s7, gy_s7, depth_s7;
	logic               zero_s7, last_s7;

	always_comb begin
		side_f = side_c[NumDivCells];
		lane_f = lane_c[NumDivCells];
		qx = lane_f[0].neg ? 16'(-lane_f[0].nq[15:0]) : lane_f[0].nq[15:0];
		qy = lane_f[1].neg ? 16'(-lane_f[1].nq[15:0]) : lane_f[1].nq[15:0];
		m_gx = qx * cfg.gain_x;
		m_gy = qy * cfg.gain_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s7           <= valid_c[NumDivCells];
			result_valid_q <= v_s7;
		end
	end

	logic signed [15:0] sx, sy;

	always_comb begin
		sx = 16'({{8{gx_s7[15]}}, gx_s7[15:8]} + 16'(CENTER_X));
		sy = 16'({{8{gy_s7[15]}}, gy_s7[15:8]} + 16'(CENTER_Y));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s7    <= m_gx[23:8];
			gy_s7    <= m_gy[23:8];
			depth_s7 <= side_f.depth;
			zero_s7  <= side_f.zero;
			last_s7  <= side_f.last;
			result_q.screen_x      <= zero_s7 ? 16'sd0 : sx;
			result_q.screen_y      <= zero_s7 ? 16'sd0 : sy;
			result_q.rotated_depth <= depth_s7;
			result_q.depth_zero    <= zero_s7;
			result_q.last_vertex   <= last_s7;
		end
	end

	a_zero_coords: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.depth_zero |->
			result_q.screen_x == 16'sd0 && result_q.screen_y == 16'sd0)
		else $error("zero divisor with nonzero coordinates");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_valid && vertex_ready |=> v_s1)
		else $error("accepted item not captured");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s7) && $stable(valid_c[NumDivCells]) && $stable(v_s1))
		else $error("pipeline moved while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !vertex_ready)
		else $error("input taken while output stalled");
endmodule
`default_nettype wire

// ===== rtl/vrp_cfg.sv =====
`default_nettype none
module vrp_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output vrp_pkg::cfg_t    cfg
);
	import vrp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_pitch       <= 16'sd256;
			cfg_q.sin_pitch       <= 16'sd0;
			cfg_q.cos_yaw         <= 16'sd256;
			cfg_q.sin_yaw         <= 16'sd0;
			cfg_q.camera_distance <= 16'sd0;
			cfg_q.gain_x          <= 16'sd256;
			cfg_q.gain_y          <= 16'sd256;
		end else if (wr) begin
			case (idx)
				REG_COS_PITCH: cfg_q.cos_pitch       <= pwdata[15:0];
				REG_SIN_PITCH: cfg_q.sin_pitch       <= pwdata[15:0];
				REG_COS_YAW:   cfg_q.cos_yaw         <= pwdata[15:0];
				REG_SIN_YAW:   cfg_q.sin_yaw         <= pwdata[15:0];
				REG_CAMERA:    cfg_q.camera_distance <= pwdata[15:0];
				REG_GAIN_X:    cfg_q.gain_x          <= pwdata[15:0];
				REG_GAIN_Y:    cfg_q.gain_y          <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COS_PITCH: prdata = {{16{cfg_q.cos_pitch[15]}}, cfg_q.cos_pitch};
			REG_SIN_PITCH: prdata = {{16{cfg_q.sin_pitch[15]}}, cfg_q.sin_pitch};
			REG_COS_YAW:   prdata = {{16{cfg_q.cos_yaw[15]}}, cfg_q.cos_yaw};
			REG_SIN_YAW:   prdata = {{16{cfg_q.sin_yaw[15]}}, cfg_q.sin_yaw};
			REG_CAMERA:    prdata = {{16{cfg_q.camera_distance[15]}}, cfg_q.camera_distance};
			REG_GAIN_X:    prdata = {{16{cfg_q.gain_x[15]}}, cfg_q.gain_x};
			REG_GAIN_Y:    prdata = {{16{cfg_q.gain_y[15]}}, cfg_q.gain_y};
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/vrp_div_cell.sv =====
`default_nettype none
module vrp_div_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     valid_i,
	input  wire vrp_pkg::div_side_t       side_i,
	input  wire vrp_pkg::div_lane_t [1:0] lane_i,
	output logic                          valid_q,
	output vrp_pkg::div_side_t            side_q,
	output vrp_pkg::div_lane_t [1:0]      lane_q
);
	import vrp_pkg::*;

	div_lane_t [1:0] lane_d;
	logic [10:0]     r2;
	logic            ge;

	// one restoring step per lane
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			r2 = {lane_i[i].rem, lane_i[i].nq[23]};
			ge = (r2 >= side_i.dmag);
			lane_d[i].rem = ge ? 10'(r2 - side_i.dmag) : r2[9:0];
			lane_d[i].nq  = {lane_i[i].nq[22:0], ge};
			lane_d[i].neg = lane_i[i].neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			lane_q <= lane_d;
		end
	end
endmodule
`default_nettype wire

// ===== tb/vrp_checker.sv =====
module vrp_checker #(
	parameter int CENTER_X = 32,
	parameter int CENTER_Y = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vertex_valid,
	input  logic             vertex_ready,
	input  vrp_pkg::vertex_t vertex,
	input  logic             result_valid,
	input  logic             result_ready,
	input  vrp_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	output int               mismatches,
	output int               pending
);
	import vrp_pkg::*;

	shortint cos_p, sin_p, cos_y, sin_y, cam, gx, gy;
	result_t expected_q[$];

	function automatic shortint rot_term(int a, shortint ca, int b, shortint cb, bit sub);
		longint s;
		s = sub ? longint'(a) * ca - longint'(b) * cb : longint'(a) * ca + longint'(b) * cb;
		return shortint'(s >>> 8);
	endfunction

	function automatic shortint to_screen(shortint v, int d, shortint gain, int centre);
		shortint q, g;
		int gs;
		q = shortint'((longint'(v) * 256) / d);
		g = shortint'((longint'(q) * gain) >>> 8);
		gs = int'(g) >>> 8;
		return shortint'(gs + centre);
	endfunction

	function automatic result_t project_vertex(vertex_t v);
		result_t r;
		int x, y, z, d;
		shortint px, pz, ry, rz;
		x = int'(v.model_x) * 256;
		y = int'(v.model_y) * 256;
		z = int'(v.model_z) * 256;
		px = rot_term(x, cos_p, z, sin_p, 1'b0);
		pz = rot_term(z, cos_p, x, sin_p, 1'b1);
		ry = rot_term(y, cos_y, pz, sin_y, 1'b0);
		rz = rot_term(pz, cos_y, y, sin_y, 1'b1);
		d = int'(shortint'(int'(rz) + cam)) >>> 5;
		r.rotated_depth = rz;
		r.last_vertex = v.end_of_object;
		r.depth_zero = (d == 0);
		if (d == 0) begin
			r.screen_x = '0;
			r.screen_y = '0;
		end else begin
			r.screen_x = to_screen(px, d, gx, CENTER_X);
			r.screen_y = to_screen(ry, d, gy, CENTER_Y);
		end
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	initial mismatches = 0;
	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cos_p = 256; sin_p = 0; cos_y = 256; sin_y = 0;
			cam = 0; gx = 256; gy = 256;
			expected_q.delete();
		end else begin
			if (vertex_valid && vertex_ready)
				expected_q.push_back(project_vertex(vertex));
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", 0, 0);
				end else begin
					want = expected_q.pop_front();
					if (result.screen_x !== want.screen_x)
						report("screen_x", result.screen_x, want.screen_x);
					if (result.screen_y !== want.screen_y)
						report("screen_y", result.screen_y, want.screen_y);
					if (result.rotated_depth !== want.rotated_depth)
						report("rotated_depth", result.rotated_depth, want.rotated_depth);
					if (result.depth_zero !== want.depth_zero)
						report("depth_zero", result.depth_zero, want.depth_zero);
					if (result.last_vertex !== want.last_vertex)
						report("last_vertex", result.last_vertex, want.last_vertex);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_COS_PITCH: cos_p = shortint'(pwdata[15:0]);
					REG_SIN_PITCH: sin_p = shortint'(pwdata[15:0]);
					REG_COS_YAW:   cos_y = shortint'(pwdata[15:0]);
					REG_SIN_YAW:   sin_y = shortint'(pwdata[15:0]);
					REG_CAMERA:    cam   = shortint'(pwdata[15:0]);
					REG_GAIN_X:    gx    = shortint'(pwdata[15:0]);
					REG_GAIN_Y:    gy    = shortint'(pwdata[15:0]);
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
module testbench;
	import vrp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic vertex_valid = 0;
	logic vertex_ready;
	vertex_t vertex = '0;
	logic result_valid;
	logic result_ready = 0;
	result_t result;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int mismatches, pending;
	bit quiet = 0;
	int ready_hold = 0;

	always #5 clk = ~clk;

	vertex_rotate_project_unit dut (.*);
	vrp_checker chk (.*);

	always @(posedge clk) begin
		if (quiet) begin
			result_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			ready_hold <= int'($urandom_range(1, 14)) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom_range(0, 65535)), val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_rotation(logic [15:0] cp, logic [15:0] sp, logic [15:0] cy,
			logic [15:0] sy, logic [15:0] cd, logic [15:0] g_x, logic [15:0] g_y);
		drain();
		write_reg(REG_COS_PITCH, cp);
		write_reg(REG_SIN_PITCH, sp);
		write_reg(REG_COS_YAW, cy);
		write_reg(REG_SIN_YAW, sy);
		write_reg(REG_CAMERA, cd);
		write_reg(REG_GAIN_X, g_x);
		write_reg(REG_GAIN_Y, g_y);
	endtask

	task automatic send_vertex(logic [7:0] x, logic [7:0] y, logic [7:0] z, logic eoo);
		vertex <= '{model_x: x, model_y: y, model_z: z, end_of_object: eoo};
		vertex_valid <= 1;
		do @(posedge clk); while (!vertex_ready);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			vertex_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] coord();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_burst(int count);
		repeat (count) send_vertex(coord(), coord(), coord(), 1'($urandom_range(0, 1)));
		vertex_valid <= 0;
	endtask

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// defaults: z of zero gives a zero divisor
		send_vertex(8'h00, 8'h00, 8'h00, 1'b0);
		send_vertex(8'h7f, 8'h7f, 8'h7f, 1'b1);
		send_vertex(8'h80, 8'h80, 8'h80, 1'b0);
		send_vertex(8'h80, 8'h7f, 8'h01, 1'b1);
		send_vertex(8'h7f, 8'h80, 8'hff, 1'b0);
		send_vertex(8'h55, 8'haa, 8'h10, 1'b1);
		send_vertex(8'haa, 8'h55, 8'hf0, 1'b0);
		send_vertex(8'h01, 8'hff, 8'h00, 1'b1);
		vertex_valid <= 0;

		// camera offset cancels depth exactly, and a divisor of minus eight
		load_rotation(16'd256, 16'd0, 16'd256, 16'd0, 16'hf000, 16'd256, 16'd256);
		send_vertex(8'h10, 8'h20, 8'h10, 1'b0);
		send_vertex(8'h7f, 8'h80, 8'h0f, 1'b1);
		send_vertex(8'h7f, 8'h7f, 8'h0f, 1'b0);
		vertex_valid <= 0;

		load_rotation(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_vertex(8'h7f, 8'h80, 8'h7f, 1'b1);
		send_vertex(8'h80, 8'h7f, 8'h80, 1'b0);
		send_vertex(8'h00, 8'h00, 8'h00, 1'b1);
		vertex_valid <= 0;

		drain();
		write_reg(REG_NONE, 16'h1234);
		random_burst(250);

		load_rotation(16'd181, 16'd181, 16'd222, 16'hff80, 16'd4000, 16'd512, 16'hff00);
		random_burst(250);

		load_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		random_burst(150);

		repeat (3) begin
			load_rotation(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 127) - 64), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
			random_burst(150);
		end

		load_rotation(16'd236, 16'hff9e, 16'd256, 16'd0, 16'd0, 16'd256, 16'd256);
		random_burst(100);

		quiet = 1;
		drain();
		random_burst(150);

		drain();
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
